// ===== design/rsc_pkg.sv =====
// shared types, codes and arithmetic helpers for the rpn stack calculator
`timescale 1ns / 1ps
package rsc_pkg;

  localparam int ValW = 48;
  localparam logic [ValW-1:0] ValMax = 48'h7FFF_FFFF_FFFF;
  localparam logic [ValW-1:0] ValMin = 48'h8000_0000_0000;

  typedef enum logic [3:0] {
    CMD_PUSH   = 4'd0,
    CMD_ADD    = 4'd1,
    CMD_SUB    = 4'd2,
    CMD_MUL    = 4'd3,
    CMD_DIV    = 4'd4,
    CMD_MOD    = 4'd5,
    CMD_SWAP   = 4'd6,
    CMD_DUP    = 4'd7,
    CMD_TOP    = 4'd8,
    CMD_CLEAR  = 4'd9,
    CMD_ASSIGN = 4'd10,
    CMD_PRINT  = 4'd11,
    CMD_LOAD   = 4'd12
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PRINT = 2'd1,
    KIND_TOP   = 2'd2
  } kind_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_START, OP_RD, OP_CAP, OP_PUSH, OP_ADD, OP_SUB, OP_MAGS,
    OP_MHH, OP_MLL, OP_MHL, OP_MLH, OP_MFIN, OP_DIVST, OP_DIVFIN, OP_MODST,
    OP_MODFIN, OP_ZDIV, OP_TOPRD, OP_TOPSHOW, OP_CLEAR, OP_ASSIGN, OP_PRINT,
    OP_LOAD, OP_INVALID, OP_FINISH
  } dp_op_e;

  typedef enum logic {DST_A, DST_B} dst_e;

  typedef enum logic [1:0] {SRC_OPND, SRC_A, SRC_B, SRC_RES} src_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_RD1, S_CAP1, S_CHK, S_RD2, S_CAP2, S_ADD, S_SUB,
    S_MAGS, S_MHH, S_MLL, S_MHL, S_MLH, S_MFIN, S_DIVST, S_MODST, S_DWAIT,
    S_DFIN, S_PUSHR, S_PUSH1, S_PUSH2, S_TOPSHOW, S_ASSIGN, S_PRINT, S_FIN
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
    dst_e   dst;
    src_e   src;
  } dp_cmd_t;

  typedef struct packed {
    logic b_zero;
    logic bi_zero;
    logic div_busy;
    logic prev_ok;
    logic vi_ok;
    logic out_block;
  } dp_stat_t;

  function automatic logic [ValW-1:0] mag48(input logic [ValW-1:0] v);
    mag48 = v[ValW-1] ? (~v + 48'd1) : v;
  endfunction

  // truncate toward zero to an integer
  function automatic logic [31:0] to_int(input logic [ValW-1:0] v);
    logic [ValW-1:0] m;
    logic [31:0] h;
    m = mag48(v);
    h = m[47:16];
    to_int = v[ValW-1] ? (~h + 32'd1) : h;
  endfunction

  // {sat, value}: apply sign to a magnitude with clipping
  function automatic logic [ValW:0] sign_sat(input logic [63:0] q, input logic neg);
    if (!neg) begin
      if (q > {16'd0, ValMax}) sign_sat = {1'b1, ValMax};
      else sign_sat = {1'b0, q[47:0]};
    end else begin
      if (q > {16'd0, ValMin}) sign_sat = {1'b1, ValMin};
      else sign_sat = {1'b0, ~q[47:0] + 48'd1};
    end
  endfunction

endpackage

// ===== design/rsc_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rsc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [47:0] divisor_i,
  output logic        busy_o,
  output logic [63:0] quot_o,
  output logic [47:0] rem_o
);
  logic [63:0] q_q, q_d;
  logic [47:0] r_q, r_d, dv_q, dv_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [48:0] trial;

  always_comb begin
    q_d = q_q;
    r_d = r_q;
    dv_d = dv_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = {r_q, q_q[63]};
    if (start_i) begin
      q_d = dividend_i;
      r_d = '0;
      dv_d = divisor_i;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dv_q}) begin
        r_d = 48'(trial - {1'b0, dv_q});
        q_d = {q_q[62:0], 1'b1};
      end else begin
        r_d = trial[47:0];
        q_d = {q_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    dv_q <= dv_d;
  end

  assign busy_o = busy_q;
  assign quot_o = q_q;
  assign rem_o = r_q;
endmodule

// ===== design/rsc_ctrl.sv =====
// command sequencer: steps the datapath through one command
`timescale 1ns / 1ps
module rsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [3:0]        req_type_i,
  input  rsc_pkg::dp_stat_t stat_i,
  output rsc_pkg::dp_cmd_t  cmd_o
);
  import rsc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [3:0]  cmd_q, cmd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q <= '0;
    end else begin
      state_q <= state_d;
      cmd_q <= cmd_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;
    cmd_o = '{op: OP_NONE, dst: DST_A, src: SRC_OPND};
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_START;
          cmd_d = req_type_i;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (cmd_q)
          CMD_PUSH: begin
            cmd_o.op = OP_PUSH;
            cmd_o.src = SRC_OPND;
            state_d = S_FIN;
          end
          CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_SWAP, CMD_DUP,
          CMD_ASSIGN, CMD_PRINT: state_d = S_RD1;
          CMD_TOP: begin
            cmd_o.op = OP_TOPRD;
            state_d = S_TOPSHOW;
          end
          CMD_CLEAR: begin
            cmd_o.op = OP_CLEAR;
            state_d = S_FIN;
          end
          CMD_LOAD: begin
            cmd_o.op = stat_i.vi_ok ? OP_LOAD : OP_INVALID;
            state_d = S_FIN;
          end
          default: begin
            cmd_o.op = OP_INVALID;
            state_d = S_FIN;
          end
        endcase
      end
      S_RD1: begin
        cmd_o.op = OP_RD;
        state_d = S_CAP1;
      end
      S_CAP1: begin
        cmd_o.op = OP_CAP;
        case (cmd_q)
          CMD_ADD, CMD_SUB, CMD_MUL: begin
            cmd_o.dst = DST_B;
            state_d = S_RD2;
          end
          CMD_DIV, CMD_MOD: begin
            cmd_o.dst = DST_B;
            state_d = S_CHK;
          end
          CMD_SWAP: state_d = S_RD2;
          CMD_DUP: state_d = S_PUSH1;
          CMD_PRINT: state_d = S_PRINT;
          default: state_d = S_CHK;
        endcase
      end
      S_CHK: begin
        case (cmd_q)
          CMD_DIV: begin
            if (stat_i.b_zero) begin
              cmd_o.op = OP_ZDIV;
              state_d = S_FIN;
            end else state_d = S_RD2;
          end
          CMD_MOD: begin
            if (stat_i.bi_zero) begin
              cmd_o.op = OP_ZDIV;
              state_d = S_FIN;
            end else state_d = S_RD2;
          end
          default: state_d = stat_i.prev_ok ? S_RD2 : S_FIN;
        endcase
      end
      S_RD2: begin
        cmd_o.op = OP_RD;
        state_d = S_CAP2;
      end
      S_CAP2: begin
        cmd_o.op = OP_CAP;
        cmd_o.dst = (cmd_q == CMD_SWAP) ? DST_B : DST_A;
        case (cmd_q)
          CMD_ADD: state_d = S_ADD;
          CMD_SUB: state_d = S_SUB;
          CMD_MUL, CMD_DIV: state_d = S_MAGS;
          CMD_MOD: state_d = S_MODST;
          CMD_SWAP: state_d = S_PUSH1;
          default: state_d = S_ASSIGN;
        endcase
      end
      S_ADD: begin
        cmd_o.op = OP_ADD;
        state_d = S_PUSHR;
      end
      S_SUB: begin
        cmd_o.op = OP_SUB;
        state_d = S_PUSHR;
      end
      S_MAGS: begin
        cmd_o.op = OP_MAGS;
        state_d = (cmd_q == CMD_MUL) ? S_MHH : S_DIVST;
      end
      S_MHH: begin
        cmd_o.op = OP_MHH;
        state_d = S_MLL;
      end
      S_MLL: begin
        cmd_o.op = OP_MLL;
        state_d = S_MHL;
      end
      S_MHL: begin
        cmd_o.op = OP_MHL;
        state_d = S_MLH;
      end
      S_MLH: begin
        cmd_o.op = OP_MLH;
        state_d = S_MFIN;
      end
      S_MFIN: begin
        cmd_o.op = OP_MFIN;
        state_d = S_PUSHR;
      end
      S_DIVST: begin
        cmd_o.op = OP_DIVST;
        state_d = S_DWAIT;
      end
      S_MODST: begin
        cmd_o.op = OP_MODST;
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (!stat_i.div_busy) state_d = S_DFIN;
      end
      S_DFIN: begin
        cmd_o.op = (cmd_q == CMD_MOD) ? OP_MODFIN : OP_DIVFIN;
        state_d = S_PUSHR;
      end
      S_PUSHR: begin
        cmd_o.op = OP_PUSH;
        cmd_o.src = SRC_RES;
        state_d = S_FIN;
      end
      S_PUSH1: begin
        cmd_o.op = OP_PUSH;
        cmd_o.src = SRC_A;
        state_d = S_PUSH2;
      end
      S_PUSH2: begin
        cmd_o.op = OP_PUSH;
        cmd_o.src = (cmd_q == CMD_SWAP) ? SRC_B : SRC_A;
        state_d = S_FIN;
      end
      S_TOPSHOW: begin
        cmd_o.op = OP_TOPSHOW;
        state_d = S_FIN;
      end
      S_ASSIGN: begin
        cmd_o.op = OP_ASSIGN;
        state_d = S_FIN;
      end
      S_PRINT: begin
        cmd_o.op = OP_PRINT;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!stat_i.out_block) begin
          cmd_o.op = OP_FINISH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

// ===== design/rsc_dpath.sv =====
// datapath: value stack, variables, arithmetic and result register
`timescale 1ns / 1ps
module rsc_dpath #(
  parameter int STACK_DEPTH = 128,
  parameter int VAR_COUNT = 26
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rsc_pkg::dp_cmd_t       cmd_i,
  output rsc_pkg::dp_stat_t      stat_o,
  input  logic signed [47:0]     operand_value_i,
  input  logic [4:0]             var_index_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic signed [47:0]     shown_value_o,
  output logic [1:0]             shown_kind_o,
  output logic                   underflow_o,
  output logic                   overflow_o,
  output logic                   zero_divide_o,
  output logic                   saturated_o,
  output logic                   invalid_command_o
);
  import rsc_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int VW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

  logic [47:0] mem [STACK_DEPTH];
  logic [47:0] rd_q;
  logic [CW-1:0] cnt_q;
  logic empty_q;
  logic [47:0] a_q, b_q, r_q, ma_q, mb_q, opnd_q;
  logic neg_q, big_q;
  logic [15:0] hh_q;
  logic [57:0] acc_q;
  logic [4:0] vi_q;
  logic [31:0] vars_q [VAR_COUNT];
  logic loaded_valid_q, prev_was_q, this_var_q;
  logic [4:0] loaded_idx_q, prev_idx_q;
  logic f_under_q, f_over_q, f_zdiv_q, f_sat_q, f_inv_q;
  logic [47:0] shown_q;
  logic [1:0] kind_q;
  logic out_valid_q;
  logic [47:0] o_val_q;
  logic [1:0] o_kind_q;
  logic o_under_q, o_over_q, o_zdiv_q, o_sat_q, o_inv_q;

  logic is_empty, is_full, push_en, rd_en;
  logic [47:0] push_val, popped;
  logic [AW-1:0] top_addr;
  logic [23:0] mx, my;
  logic [47:0] prod;
  logic [48:0] sum, sres;
  logic [63:0] mq;
  logic [48:0] msat, dsat;
  logic [31:0] ai, bi, aim, bim, rsgn;
  logic div_start, div_busy;
  logic [63:0] div_dividend, div_quot;
  logic [47:0] div_divisor, div_rem;

  assign is_empty = (cnt_q == '0);
  assign is_full = (cnt_q == CW'(STACK_DEPTH));
  assign top_addr = AW'(cnt_q - CW'(1));
  assign popped = empty_q ? '0 : rd_q;
  assign ai = to_int(a_q);
  assign bi = to_int(b_q);
  assign aim = ai[31] ? (~ai + 32'd1) : ai;
  assign bim = bi[31] ? (~bi + 32'd1) : bi;
  assign rsgn = ai[31] ? (~div_rem[31:0] + 32'd1) : div_rem[31:0];

  always_comb begin
    push_en = (cmd_i.op == OP_PUSH) || (cmd_i.op == OP_LOAD);
    case (cmd_i.src)
      SRC_OPND: push_val = opnd_q;
      SRC_A:    push_val = a_q;
      SRC_B:    push_val = b_q;
      default:  push_val = r_q;
    endcase
    if (cmd_i.op == OP_LOAD) push_val = {vars_q[vi_q[VW-1:0]], 16'd0};
    rd_en = ((cmd_i.op == OP_RD) && !is_empty) || (cmd_i.op == OP_TOPRD);
  end

  // one shared 24x24 multiplier over four partial products
  always_comb begin
    case (cmd_i.op)
      OP_MHH:  begin mx = ma_q[47:24]; my = mb_q[47:24]; end
      OP_MLL:  begin mx = ma_q[23:0];  my = mb_q[23:0];  end
      OP_MHL:  begin mx = ma_q[47:24]; my = mb_q[23:0];  end
      default: begin mx = ma_q[23:0];  my = mb_q[47:24]; end
    endcase
    prod = mx * my;
  end

  always_comb begin
    sum = (cmd_i.op == OP_SUB) ? ({a_q[47], a_q} - {b_q[47], b_q})
                               : ({a_q[47], a_q} + {b_q[47], b_q});
    if (sum[48] != sum[47]) sres = {1'b1, sum[48] ? ValMin : ValMax};
    else sres = {1'b0, sum[47:0]};
    mq = big_q ? 64'h0000_FFFF_FFFF_FFFF
               : (64'({hh_q, 32'd0}) + 64'(acc_q));
  end

  assign msat = sign_sat(mq, neg_q);
  assign dsat = sign_sat(div_quot, neg_q);

  assign div_start = (cmd_i.op == OP_DIVST) || (cmd_i.op == OP_MODST);
  assign div_dividend = (cmd_i.op == OP_DIVST) ? {ma_q, 16'd0} : 64'(aim);
  assign div_divisor = (cmd_i.op == OP_DIVST) ? mb_q : 48'(bim);

  rsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // stack memory
  always_ff @(posedge clk_i) begin
    if (push_en && !is_full) mem[cnt_q[AW-1:0]] <= push_val;
    if (rd_en) rd_q <= mem[top_addr];
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: opnd_q <= operand_value_i;
      OP_CAP: begin
        if (cmd_i.dst == DST_A) a_q <= popped;
        else b_q <= popped;
      end
      OP_ADD, OP_SUB: r_q <= sres[47:0];
      OP_MAGS: begin
        ma_q <= mag48(a_q);
        mb_q <= mag48(b_q);
        neg_q <= a_q[47] ^ b_q[47];
      end
      OP_MHH: begin
        big_q <= (prod[47:16] != '0);
        hh_q <= prod[15:0];
      end
      OP_MLL: acc_q <= 58'(prod[47:16]);
      OP_MHL, OP_MLH: acc_q <= acc_q + 58'({prod, 8'd0});
      OP_MFIN: r_q <= msat[47:0];
      OP_DIVFIN: r_q <= dsat[47:0];
      OP_MODFIN: r_q <= {rsgn, 16'd0};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      empty_q <= 1'b1;
      vi_q <= '0;
      for (int i = 0; i < VAR_COUNT; i++) vars_q[i] <= '0;
      loaded_valid_q <= 1'b0;
      loaded_idx_q <= '0;
      prev_was_q <= 1'b0;
      prev_idx_q <= '0;
      this_var_q <= 1'b0;
      {f_under_q, f_over_q, f_zdiv_q, f_sat_q, f_inv_q} <= '0;
      shown_q <= '0;
      kind_q <= KIND_NONE;
      out_valid_q <= 1'b0;
      o_val_q <= '0;
      o_kind_q <= KIND_NONE;
      {o_under_q, o_over_q, o_zdiv_q, o_sat_q, o_inv_q} <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (cmd_i.op != OP_FINISH)) out_valid_q <= 1'b0;
      if (push_en) begin
        if (is_full) f_over_q <= 1'b1;
        else cnt_q <= cnt_q + CW'(1);
      end
      case (cmd_i.op)
        OP_START: begin
          vi_q <= var_index_i;
          {f_under_q, f_over_q, f_zdiv_q, f_sat_q, f_inv_q} <= '0;
          shown_q <= '0;
          kind_q <= KIND_NONE;
          this_var_q <= 1'b0;
        end
        OP_RD: begin
          empty_q <= is_empty;
          if (is_empty) f_under_q <= 1'b1;
          else cnt_q <= cnt_q - CW'(1);
        end
        OP_TOPRD: empty_q <= is_empty;
        OP_TOPSHOW: begin
          kind_q <= KIND_TOP;
          shown_q <= popped;
          if (empty_q) f_under_q <= 1'b1;
        end
        OP_ADD, OP_SUB: if (sres[48]) f_sat_q <= 1'b1;
        OP_MFIN: if (msat[48]) f_sat_q <= 1'b1;
        OP_DIVFIN: if (dsat[48]) f_sat_q <= 1'b1;
        OP_ZDIV: f_zdiv_q <= 1'b1;
        OP_CLEAR: cnt_q <= '0;
        OP_ASSIGN: begin
          vars_q[prev_idx_q[VW-1:0]] <= ai;
          loaded_valid_q <= 1'b0;
        end
        OP_PRINT: begin
          if (loaded_valid_q && (loaded_idx_q < 5'(VAR_COUNT)))
            vars_q[loaded_idx_q[VW-1:0]] <= ai;
          shown_q <= a_q;
          kind_q <= KIND_PRINT;
        end
        OP_LOAD: begin
          loaded_valid_q <= 1'b1;
          loaded_idx_q <= vi_q;
          this_var_q <= 1'b1;
        end
        OP_INVALID: f_inv_q <= 1'b1;
        OP_FINISH: begin
          prev_was_q <= this_var_q;
          if (this_var_q) prev_idx_q <= vi_q;
          out_valid_q <= 1'b1;
          o_val_q <= shown_q;
          o_kind_q <= kind_q;
          {o_under_q, o_over_q, o_zdiv_q, o_sat_q, o_inv_q} <=
              {f_under_q, f_over_q, f_zdiv_q, f_sat_q, f_inv_q};
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat_o.b_zero = (b_q == '0);
    stat_o.bi_zero = (bi == '0);
    stat_o.div_busy = div_busy;
    stat_o.prev_ok = prev_was_q && (prev_idx_q < 5'(VAR_COUNT));
    stat_o.vi_ok = (vi_q < 5'(VAR_COUNT));
    stat_o.out_block = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign shown_value_o = o_val_q;
  assign shown_kind_o = o_kind_q;
  assign underflow_o = o_under_q;
  assign overflow_o = o_over_q;
  assign zero_divide_o = o_zdiv_q;
  assign saturated_o = o_sat_q;
  assign invalid_command_o = o_inv_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_CLEAR |=> cnt_q == '0)
    else $error("clear did not empty the stack");

  a_zdiv_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && o_zdiv_q |-> o_kind_q == KIND_NONE)
    else $error("zero divide item also shows a value");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");
endmodule

// ===== design/rpn_stack_calculator_top.sv =====
// rpn stack calculator: sequencer plus datapath with value stack and variables
//
// one command item enters on the input channel (in_valid_i / in_ready_o)
// and exactly one result item leaves on the output channel
// (out_valid_o / out_ready_i) carrying the shown value, its kind and flags.
// commands run one at a time; in_ready_o is high only while the sequencer
// is idle; the result turns valid as the sequencer returns to idle.
// mul uses four 24x24 partial products on one multiplier, and div and mod
// use the 64-step radix-2 divider. the result sits in an output register,
// so the next item is accepted while it waits; a stalled receiver holds
// the block only when a second result is ready before the first is taken.
// reset clears the stack count, the variables, the load marks and the
// output valid; stack memory contents are not cleared and need no sweep.
`timescale 1ns / 1ps
module rpn_stack_calculator_top #(
  parameter int STACK_DEPTH = 128,
  parameter int VAR_COUNT = 26
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         req_type_i,
  input  logic signed [47:0] operand_value_i,
  input  logic [4:0]         var_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [47:0] shown_value_o,
  output logic [1:0]         shown_kind_o,
  output logic               underflow_o,
  output logic               overflow_o,
  output logic               zero_divide_o,
  output logic               saturated_o,
  output logic               invalid_command_o
);
  import rsc_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  rsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  rsc_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VAR_COUNT   (VAR_COUNT)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (dp_cmd),
    .stat_o            (dp_stat),
    .operand_value_i   (operand_value_i),
    .var_index_i       (var_index_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .shown_value_o     (shown_value_o),
    .shown_kind_o      (shown_kind_o),
    .underflow_o       (underflow_o),
    .overflow_o        (overflow_o),
    .zero_divide_o     (zero_divide_o),
    .saturated_o       (saturated_o),
    .invalid_command_o (invalid_command_o)
  );
endmodule
